FILE: rtl/aabb_pkg.sv
// Shared types and constants for the box pair collision scan block.
package aabb_pkg;

  localparam int SLOT_COUNT  = 32;
  localparam int COORD_BITS  = 16;
  localparam int EXT_BITS    = COORD_BITS - 1;
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int INDEX_BITS  = 5;
  localparam int LIMIT_BITS  = 6;
  localparam int ADDRESSABLE = 32;
  localparam int LIMIT_CAP   = (SLOT_COUNT < ADDRESSABLE) ? SLOT_COUNT : ADDRESSABLE;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  typedef struct packed {
    logic                         operation;
    logic [INDEX_BITS-1:0]        slot;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [EXT_BITS-1:0]          half_width;
    logic [EXT_BITS-1:0]          half_height;
    logic                         enabled;
    logic                         is_static;
    logic                         occupied;
    logic [LIMIT_BITS-1:0]        slot_limit;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] self_index;
    logic [INDEX_BITS-1:0] other_index;
    logic                  last;
  } pair_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [EXT_BITS-1:0]          hw;
    logic [EXT_BITS-1:0]          hh;
    logic                         en;
    logic                         st;
    logic                         occ;
  } box_t;

endpackage

FILE: rtl/aabb_ram.sv
// Generic single write port RAM with registered read.
module aabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/aabb_cmp.sv
// Strict overlap compare of the held box against one box from the table.
module aabb_cmp (
  input  aabb_pkg::box_t a,
  input  aabb_pkg::box_t b,
  output logic           hit
);

  localparam int DW = aabb_pkg::COORD_BITS + 1;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;
  logic [DW-1:0]        sum_w, sum_h;

  // |a.c - b.c| < a.h + b.h on each axis is the same as both strict inequalities
  assign dx    = DW'(a.cx) - DW'(b.cx);
  assign dy    = DW'(a.cy) - DW'(b.cy);
  assign adx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady   = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign sum_w = DW'(a.hw) + DW'(b.hw);
  assign sum_h = DW'(a.hh) + DW'(b.hh);
  assign hit   = (adx < sum_w) && (ady < sum_h);

endmodule

FILE: rtl/aabb_pair_collision_scan_core.sv
// Box table with one-at-a-time pair scan against higher slots.
// A write transaction leaves the block idle and ready again at once.
// A scan fetches the self box, then walks the slots from self+1 up to, but not
// including, the limit (one table read and one shared compare each), then
// flushes the held hit; a stalled output holds the walk at a second hit.
// Reset clears the slot valid bits (all boxes read as disabled) and the control.
module aabb_pair_collision_scan_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  aabb_pkg::item_t item,
  output logic            pair_valid,
  input  logic            pair_stall,
  output aabb_pkg::pair_t pair
);

  localparam int SB = aabb_pkg::SLOT_BITS;
  localparam int LB = aabb_pkg::LIMIT_BITS;
  localparam int IB = aabb_pkg::INDEX_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SELF  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                        state;
  logic [IB-1:0]                     self_idx;
  logic [LB-1:0]                     limit;
  logic [LB-1:0]                     cur;
  aabb_pkg::box_t                    self_box;
  logic                              p_valid;
  logic [IB-1:0]                     p_other;
  logic [aabb_pkg::SLOT_COUNT-1:0]   written;

  aabb_pkg::box_t wbox, rbox;
  logic           accept, in_range, wr_en;
  logic [LB-1:0]  lim_eff, cur_plus, self_plus;
  logic [SB-1:0]  raddr;
  logic           self_ok, other_ok, cmp_hit, hit, out_free, blocked, pair_load;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_range   = (32'(item.slot) < aabb_pkg::SLOT_COUNT);
  assign wr_en      = accept && (item.operation == aabb_pkg::OP_WRITE) && in_range;
  assign lim_eff    = (item.slot_limit > LB'(aabb_pkg::LIMIT_CAP)) ?
                      LB'(aabb_pkg::LIMIT_CAP) : item.slot_limit;

  assign wbox.cx  = item.center_x;
  assign wbox.cy  = item.center_y;
  assign wbox.hw  = item.half_width;
  assign wbox.hh  = item.half_height;
  assign wbox.en  = item.enabled;
  assign wbox.st  = item.is_static;
  assign wbox.occ = item.occupied;

  aabb_ram #(
    .WIDTH($bits(aabb_pkg::box_t)),
    .DEPTH(aabb_pkg::SLOT_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(SB'(item.slot)),
    .wdata(wbox),
    .raddr(raddr),
    .rdata(rbox)
  );

  aabb_cmp u_cmp (
    .a  (self_box),
    .b  (rbox),
    .hit(cmp_hit)
  );

  assign cur_plus  = cur + LB'(1);
  assign self_plus = LB'(self_idx) + LB'(1);
  assign self_ok   = written[SB'(self_idx)] && rbox.en && !rbox.st && rbox.occ;
  assign other_ok  = written[SB'(cur)] && rbox.en;
  assign hit       = other_ok && cmp_hit;
  assign out_free  = !pair_valid || !pair_stall;
  // a second hit needs the output register to take the pending one
  assign blocked   = hit && p_valid && !out_free;
  assign pair_load = ((state == ST_SCAN) && !blocked && hit && p_valid) ||
                     ((state == ST_FLUSH) && p_valid && out_free);

  always_comb begin
    unique case (state)
      ST_IDLE:  raddr = SB'(item.slot);
      ST_SELF:  raddr = SB'(self_plus);
      ST_SCAN:  raddr = blocked ? SB'(cur) : SB'(cur_plus);
      default:  raddr = SB'(cur);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      p_valid    <= 1'b0;
      pair_valid <= 1'b0;
      written    <= '0;
    end else begin
      if (pair_load) begin
        pair_valid <= 1'b1;
      end else if (pair_valid && !pair_stall) begin
        pair_valid <= 1'b0;
      end
      if (wr_en) begin
        written[SB'(item.slot)] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (item.operation == aabb_pkg::OP_SCAN) && in_range) begin
            self_idx <= item.slot;
            limit    <= lim_eff;
            state    <= ST_SELF;
          end
        end
        ST_SELF: begin
          self_box <= rbox;
          cur      <= self_plus;
          if (self_ok && (self_plus < limit)) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (!blocked) begin
            if (hit) begin
              // release the older hit, hold the new one until the next or the end
              if (p_valid) begin
                pair.self_index  <= self_idx;
                pair.other_index <= p_other;
                pair.last        <= 1'b0;
              end
              p_valid <= 1'b1;
              p_other <= IB'(cur);
            end
            if (cur_plus >= limit) begin
              state <= ST_FLUSH;
            end else begin
              cur <= cur_plus;
            end
          end
        end
        ST_FLUSH: begin
          if (!p_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pair.self_index  <= self_idx;
            pair.other_index <= p_other;
            pair.last        <= 1'b1;
            p_valid          <= 1'b0;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
